>>> rtl/tdpt_pkg.sv
// Package for the trial-division prime test unit.
// Holds the sequencer step codes, jump conditions, control word and microcode ROM.
// No dependencies.
`default_nettype none

package tdpt_pkg;

   localparam int STEP_BITS = 3;
   localparam int FIRST_DIVISOR = 2;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_SMALL = 3'd1;
   localparam step_type STEP_BOUND = 3'd2;
   localparam step_type STEP_DIVI  = 3'd3;
   localparam step_type STEP_DIVS  = 3'd4;
   localparam step_type STEP_REMC  = 3'd5;
   localparam step_type STEP_LOOP  = 3'd6;
   localparam step_type STEP_EMIT  = 3'd7;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_SMALL,
      COND_SQ_GT_V,
      COND_DIV_BUSY,
      COND_REM_ZERO,
      COND_OUT_BUSY
   } cond_type;

   // taken: pc <= target, else pc <= pc + 1
   typedef struct packed {
      cond_type cond;
      step_type target;
      logic     act_load;
      logic     act_mark;
      logic     act_div_init;
      logic     act_div_step;
      logic     act_next_div;
      logic     act_emit;
   } ctrl_type;

   function automatic ctrl_type ucode_rom(input step_type pc);
      ctrl_type cw;
      cw = '{cond: COND_NEVER, target: STEP_IDLE, default: 1'b0};
      case (pc)
         STEP_IDLE: begin
            cw.cond = COND_NO_REQ;  cw.target = STEP_IDLE;  cw.act_load = 1'b1;
         end
         STEP_SMALL: begin
            cw.cond = COND_SMALL;   cw.target = STEP_EMIT;
         end
         STEP_BOUND: begin
            cw.cond = COND_SQ_GT_V; cw.target = STEP_EMIT;  cw.act_mark = 1'b1;
         end
         STEP_DIVI: begin
            cw.cond = COND_NEVER;   cw.target = STEP_IDLE;  cw.act_div_init = 1'b1;
         end
         STEP_DIVS: begin
            cw.cond = COND_DIV_BUSY; cw.target = STEP_DIVS; cw.act_div_step = 1'b1;
         end
         STEP_REMC: begin
            cw.cond = COND_REM_ZERO; cw.target = STEP_EMIT; cw.act_next_div = 1'b1;
         end
         STEP_LOOP: begin
            cw.cond = COND_ALWAYS;  cw.target = STEP_BOUND;
         end
         STEP_EMIT: begin
            cw.cond = COND_OUT_BUSY; cw.target = STEP_EMIT; cw.act_emit = 1'b1;
         end
         default: begin
            cw.cond = COND_ALWAYS;  cw.target = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

>>> rtl/trial_division_prime_test_unit.sv
// Trial-division prime test unit: microcoded sequencer over a shift-subtract divider.
// Depends on tdpt_pkg (step codes, conditions, microcode ROM).
//
// Usage: one candidate per req item, one rsp item per candidate carrying the
// candidate back and is_prime. Values 0 and 1 are not prime.
// The unit tests divisors d = 2, 3, ... while d*d <= candidate and stops at
// the first exact divisor. For each divisor the sequencer checks the bound,
// starts the remainder unit, which works out one bit per cycle, and then
// checks the remainder. One item is worked on at a time: req_stall is low
// only in the idle step.
// The result sits in an output register, so the next item is accepted while
// a result waits; a held result only blocks the unit when a second result is
// ready. rsp_stall holds rsp_valid and the payload steady.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_valid; no clearing pass is needed.
`default_nettype none

module trial_division_prime_test_unit #(
   parameter int VALUE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [VALUE_BITS-1:0] req_candidate,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [VALUE_BITS-1:0]      rsp_tested_value,
   output logic                       rsp_is_prime
);
   import tdpt_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   step_type                pc_ff, pc_in;
   logic [VALUE_BITS-1:0]   v_ff, v_in;
   logic [VALUE_BITS-1:0]   d_ff, d_in;
   logic [VALUE_BITS:0]     sq_ff, sq_in;
   logic [VALUE_BITS-1:0]   rem_ff, rem_in;
   logic [VALUE_BITS-1:0]   q_ff, q_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    flag_ff, flag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                    rsp_prime_ff, rsp_prime_in;

   ctrl_type                cw;
   logic                    cond_true;
   logic [VALUE_BITS:0]     rem_sh;
   logic [VALUE_BITS:0]     d_ext;
   logic [VALUE_BITS:0]     rem_sub;

   assign cw = ucode_rom(pc_ff);

   always_comb begin
      case (cw.cond)
         COND_NEVER:    cond_true = 1'b0;
         COND_ALWAYS:   cond_true = 1'b1;
         COND_NO_REQ:   cond_true = !req_valid;
         COND_SMALL:    cond_true = (v_ff[VALUE_BITS-1:1] == '0);
         COND_SQ_GT_V:  cond_true = (sq_ff > {1'b0, v_ff});
         COND_DIV_BUSY: cond_true = (cnt_ff != CNT_BITS'(1));
         COND_REM_ZERO: cond_true = (rem_ff == '0);
         COND_OUT_BUSY: cond_true = rsp_valid_ff && rsp_stall;
         default:       cond_true = 1'b1;
      endcase
   end

   assign rem_sh  = {rem_ff, q_ff[VALUE_BITS-1]};
   assign d_ext   = {1'b0, d_ff};
   assign rem_sub = rem_sh - d_ext;

   always_comb begin
      pc_in        = cond_true ? cw.target : step_type'(pc_ff + 1'b1);
      v_in         = v_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_prime_in = rsp_prime_ff;

      if (cw.act_load && req_valid) begin
         v_in    = req_candidate;
         d_in    = VALUE_BITS'(FIRST_DIVISOR);
         sq_in   = (VALUE_BITS + 1)'(FIRST_DIVISOR * FIRST_DIVISOR);
         flag_in = 1'b0;
      end
      if (cw.act_mark && cond_true) begin
         flag_in = 1'b1;
      end
      if (cw.act_div_init) begin
         rem_in = '0;
         q_in   = v_ff;
         cnt_in = CNT_BITS'(VALUE_BITS);
      end
      if (cw.act_div_step) begin
         rem_in = (rem_sh >= d_ext) ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
         q_in   = {q_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end
      if (cw.act_next_div) begin
         d_in  = d_ff + 1'b1;
         sq_in = sq_ff + {d_ff, 1'b1};
      end
      if (cw.act_emit && !cond_true) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = v_ff;
         rsp_prime_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      flag_ff      <= flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_prime_ff <= rsp_prime_in;
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall        = (pc_ff != STEP_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tested_value = rsp_value_ff;
   assign rsp_is_prime     = rsp_prime_ff;

   a_prime_ge_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime |-> rsp_tested_value > VALUE_BITS'(1))
      else $error("prime flag on value below two");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while busy");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_DIVS |-> rem_ff < d_ff && cnt_ff != '0)
      else $error("remainder unit out of range");

   a_divisor_min: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_REMC |-> d_ff >= VALUE_BITS'(FIRST_DIVISOR))
      else $error("divisor below two");

endmodule

`default_nettype wire
